@@ hw/rtl/sbdg_pkg.sv @@
// Shared types and constants of the stereo box decimator with gain.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package sbdg_pkg;

  // Sample and level formats
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 7;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd50;

  // Group length default
  localparam int unsigned DECIMATION_DEFAULT = 3;

  // Magnitude of a group average (up to 32768) and of average times level
  localparam int unsigned QUOT_W = SAMPLE_W + 1;
  localparam int unsigned GAIN_W = QUOT_W + LEVEL_W;

  // Divide by the unity level through a reciprocal multiply, exact for
  // any magnitude below 2**GAIN_W (shift = width + ceil(log2(50)))
  localparam int unsigned UNITY_LEVEL = 50;
  localparam int unsigned GAIN_DIV_S  = GAIN_W + $clog2(UNITY_LEVEL);
  localparam int unsigned GAIN_DIV_MW = GAIN_W + 1;
  localparam longint unsigned GAIN_DIV_M =
    ((64'd1 << GAIN_DIV_S) + UNITY_LEVEL - 1) / UNITY_LEVEL;

  // Saturation bounds
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;
  localparam logic [QUOT_W-1:0] MAG_POS_LIMIT = 17'd32767;
  localparam logic [QUOT_W-1:0] MAG_NEG_LIMIT = 17'd32768;

  // Load enables of the scaling stages, shared by both channel lanes
  typedef struct packed {
    logic ld_b;
    logic ld_c;
    logic ld_d;
    logic ld_o;
  } stage_en_t;

endpackage

`default_nettype wire

@@ hw/rtl/sbdg_if.sv @@
// Valid/ready channel interfaces: input frames, output frames, level writes.
// Depends on sbdg_pkg for the field widths.
`default_nettype none

interface sbdg_frame_in_if;
  logic valid;
  logic ready;
  logic signed [sbdg_pkg::SAMPLE_W-1:0] left_in;
  logic signed [sbdg_pkg::SAMPLE_W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface sbdg_frame_out_if;
  logic valid;
  logic ready;
  logic signed [sbdg_pkg::SAMPLE_W-1:0] left_out;
  logic signed [sbdg_pkg::SAMPLE_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface sbdg_cfg_if;
  logic valid;
  logic ready;
  logic [sbdg_pkg::LEVEL_W-1:0] gain;

  modport source (output valid, output gain, input ready);
  modport sink (input valid, input gain, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sbdg_accum.sv @@
// Group accumulator: sums left and right over DECIMATION frames and hands
// the closed group sums to the scaling lanes. Depends on sbdg_pkg.
`default_nettype none

module sbdg_accum #(
  parameter int unsigned DECIMATION = sbdg_pkg::DECIMATION_DEFAULT,
  localparam int unsigned SUM_W     = sbdg_pkg::SAMPLE_W + $clog2(DECIMATION),
  localparam int unsigned PHASE_W   = $clog2(DECIMATION)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [sbdg_pkg::SAMPLE_W-1:0] left_in,
  input  wire logic signed [sbdg_pkg::SAMPLE_W-1:0] right_in,
  input  wire logic                                ld_a,
  output logic                                     a_valid,
  output logic signed [SUM_W-1:0]                  left_sum,
  output logic signed [SUM_W-1:0]                  right_sum
);

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(DECIMATION - 1);
  localparam int unsigned EXT_W = SUM_W - sbdg_pkg::SAMPLE_W;

  logic [PHASE_W-1:0]     phase;
  logic signed [SUM_W-1:0] left_acc;
  logic signed [SUM_W-1:0] right_acc;
  logic signed [SUM_W-1:0] left_total;
  logic signed [SUM_W-1:0] right_total;
  logic                   last;
  logic                   accept;

  // Closing frame needs room downstream; other frames always go in
  assign last     = (phase == LAST_PHASE);
  assign in_ready = !last || ld_a;
  assign accept   = in_valid && in_ready;

  assign left_total  = left_acc + {{EXT_W{left_in[sbdg_pkg::SAMPLE_W-1]}}, left_in};
  assign right_total = right_acc + {{EXT_W{right_in[sbdg_pkg::SAMPLE_W-1]}}, right_in};

  // Advance phase and running sums; flag a closed group
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      left_acc  <= '0;
      right_acc <= '0;
      a_valid   <= 1'b0;
    end else begin
      if (ld_a) begin
        a_valid <= accept && last;
      end
      if (accept) begin
        if (last) begin
          phase     <= '0;
          left_acc  <= '0;
          right_acc <= '0;
        end else begin
          phase     <= phase + 1'b1;
          left_acc  <= left_total;
          right_acc <= right_total;
        end
      end
    end
  end

  // Capture the group totals
  always_ff @(posedge clk) begin
    if (accept && last) begin
      left_sum  <= left_total;
      right_sum <= right_total;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sbdg_lane.sv @@
// One channel of the scaling pipeline: divide by DECIMATION, apply level,
// divide by 50, saturate. Works on magnitude plus sign. Depends on sbdg_pkg.
`default_nettype none

module sbdg_lane #(
  parameter int unsigned DECIMATION = sbdg_pkg::DECIMATION_DEFAULT,
  localparam int unsigned SUM_W     = sbdg_pkg::SAMPLE_W + $clog2(DECIMATION)
) (
  input  wire logic                                clk,
  input  wire sbdg_pkg::stage_en_t                 en,
  input  wire logic signed [SUM_W-1:0]             sum,
  input  wire logic [sbdg_pkg::LEVEL_W-1:0]        level,
  output logic signed [sbdg_pkg::SAMPLE_W-1:0]     sample_out
);

  // Reciprocal of DECIMATION, exact for magnitudes below 2**SUM_W
  localparam int unsigned DEC_S  = SUM_W + $clog2(DECIMATION);
  localparam int unsigned DEC_MW = SUM_W + 1;
  localparam longint unsigned DEC_M =
    ((64'd1 << DEC_S) + DECIMATION - 1) / DECIMATION;
  localparam int unsigned DEC_PW = SUM_W + DEC_MW;
  localparam int unsigned DIV_PW = sbdg_pkg::GAIN_W + sbdg_pkg::GAIN_DIV_MW;

  logic                           sum_neg;
  logic [SUM_W-1:0]               sum_mag;
  logic [DEC_PW-1:0]              dec_prod;
  logic [DIV_PW-1:0]              div_prod;

  logic                           b_neg;
  logic [sbdg_pkg::QUOT_W-1:0]    b_mag;
  logic                           c_neg;
  logic [sbdg_pkg::GAIN_W-1:0]    c_mag;
  logic                           d_neg;
  logic [sbdg_pkg::QUOT_W-1:0]    d_mag;
  logic signed [sbdg_pkg::SAMPLE_W-1:0] sat_val;

  // Stage B: average magnitude by reciprocal multiply
  assign sum_neg  = sum[SUM_W-1];
  assign sum_mag  = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign dec_prod = DEC_PW'(sum_mag) * DEC_PW'(DEC_MW'(DEC_M));

  // Stage D: divide gained magnitude by the unity level
  assign div_prod = DIV_PW'(c_mag) *
                    DIV_PW'(sbdg_pkg::GAIN_DIV_MW'(sbdg_pkg::GAIN_DIV_M));

  // Output: restore sign and clamp to the sample range
  always_comb begin
    if (d_neg) begin
      if (d_mag >= sbdg_pkg::MAG_NEG_LIMIT) begin
        sat_val = sbdg_pkg::SAT_MIN;
      end else begin
        sat_val = -$signed(d_mag[sbdg_pkg::SAMPLE_W-1:0]);
      end
    end else begin
      if (d_mag > sbdg_pkg::MAG_POS_LIMIT) begin
        sat_val = sbdg_pkg::SAT_MAX;
      end else begin
        sat_val = $signed(d_mag[sbdg_pkg::SAMPLE_W-1:0]);
      end
    end
  end

  // Stage registers, each loaded when its slot is free or moving on
  always_ff @(posedge clk) begin
    if (en.ld_b) begin
      b_neg <= sum_neg;
      b_mag <= dec_prod[DEC_S +: sbdg_pkg::QUOT_W];
    end
    if (en.ld_c) begin
      c_neg <= b_neg;
      c_mag <= sbdg_pkg::GAIN_W'(b_mag) * sbdg_pkg::GAIN_W'(level);
    end
    if (en.ld_d) begin
      d_neg <= c_neg;
      d_mag <= div_prod[sbdg_pkg::GAIN_DIV_S +: sbdg_pkg::QUOT_W];
    end
    if (en.ld_o) begin
      sample_out <= sat_val;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stereo_box_decimator_gain_top.sv @@
// Stereo box decimator with gain: top level, stage valid chain, level register.
// Depends on sbdg_pkg, sbdg_if.sv, sbdg_accum and sbdg_lane.
//
// Takes one signed 16-bit stereo frame per clock and emits one stereo frame
// for every DECIMATION frames: the group sum divided by DECIMATION, times
// the gain level, divided by 50 (both divisions truncate toward zero), then
// saturated to 16 bits; level 50 is unity. After the transfer of the frame
// that closes a group, the result passes through the accumulator register
// and the average, gain and divide registers, after which the saturated
// result sits in the output register until its transfer. Sustained rate is
// one frame per cycle; each stage holds while its successor is full, so
// input stalls only once every stage is backed up behind a stalled output.
// The gain level is written on the cfg channel, which is always ready; write
// it only while no frames are in flight.
`default_nettype none

module stereo_box_decimator_gain_top #(
  parameter int unsigned DECIMATION = sbdg_pkg::DECIMATION_DEFAULT
) (
  input wire logic           clk,
  input wire logic           rst,
  sbdg_frame_in_if.sink      frame_in,
  sbdg_frame_out_if.source   frame_out,
  sbdg_cfg_if.sink           cfg
);

  localparam int unsigned SUM_W = sbdg_pkg::SAMPLE_W + $clog2(DECIMATION);

  logic [sbdg_pkg::LEVEL_W-1:0] level;
  logic                         a_valid;
  logic                         b_valid;
  logic                         c_valid;
  logic                         d_valid;
  logic                         o_valid;
  logic                         a_ready;
  logic                         b_ready;
  logic                         c_ready;
  logic                         d_ready;
  logic                         o_ready;
  sbdg_pkg::stage_en_t          en;
  logic signed [SUM_W-1:0]      left_sum;
  logic signed [SUM_W-1:0]      right_sum;

  // Level register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= sbdg_pkg::LEVEL_RESET;
    end else if (cfg.valid) begin
      level <= cfg.gain;
    end
  end

  // A slot takes new data when empty or when its content moves on
  always_comb begin
    o_ready = !o_valid || frame_out.ready;
    d_ready = !d_valid || o_ready;
    c_ready = !c_valid || d_ready;
    b_ready = !b_valid || c_ready;
    a_ready = !a_valid || b_ready;
    en.ld_b = b_ready;
    en.ld_c = c_ready;
    en.ld_d = d_ready;
    en.ld_o = o_ready;
  end

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
      if (o_ready) begin
        o_valid <= d_valid;
      end
    end
  end

  assign frame_out.valid = o_valid;

  sbdg_accum #(
    .DECIMATION (DECIMATION)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame_in.valid),
    .in_ready  (frame_in.ready),
    .left_in   (frame_in.left_in),
    .right_in  (frame_in.right_in),
    .ld_a      (a_ready),
    .a_valid   (a_valid),
    .left_sum  (left_sum),
    .right_sum (right_sum)
  );

  sbdg_lane #(
    .DECIMATION (DECIMATION)
  ) u_lane_left (
    .clk        (clk),
    .en         (en),
    .sum        (left_sum),
    .level      (level),
    .sample_out (frame_out.left_out)
  );

  sbdg_lane #(
    .DECIMATION (DECIMATION)
  ) u_lane_right (
    .clk        (clk),
    .en         (en),
    .sum        (right_sum),
    .level      (level),
    .sample_out (frame_out.right_out)
  );

endmodule

`default_nettype wire

@@ hw/rtl/sbdg_checker.sv @@
// Port-level checks of the stereo box decimator with gain, and the bind that
// attaches them to the top level. Depends on sbdg_pkg.
`default_nettype none

module sbdg_assert #(
  parameter int unsigned DECIMATION = sbdg_pkg::DECIMATION_DEFAULT,
  localparam int unsigned PHASE_W   = $clog2(DECIMATION)
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [sbdg_pkg::SAMPLE_W-1:0] left_out,
  input wire logic signed [sbdg_pkg::SAMPLE_W-1:0] right_out,
  input wire logic                                cfg_valid,
  input wire logic                                cfg_ready,
  input wire logic [sbdg_pkg::LEVEL_W-1:0]        cfg_level
);

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(DECIMATION - 1);

  logic [PHASE_W-1:0]           phase;
  logic [3:0]                   pending;
  logic [sbdg_pkg::LEVEL_W-1:0] level;
  logic                         in_xfer;
  logic                         out_xfer;
  logic                         group_done;

  assign in_xfer    = in_valid && in_ready;
  assign out_xfer   = out_valid && out_ready;
  assign group_done = in_xfer && (phase == LAST_PHASE);

  // Track group phase, closed groups not yet delivered, and the level
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      pending <= '0;
      level   <= sbdg_pkg::LEVEL_RESET;
    end else begin
      if (in_xfer) begin
        phase <= group_done ? '0 : phase + 1'b1;
      end
      pending <= pending + {3'd0, group_done} - {3'd0, out_xfer};
      if (cfg_valid && cfg_ready) begin
        level <= cfg_level;
      end
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled output changed");

  // Every output transfer belongs to a closed group
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> pending != 4'd0)
    else $error("output without a closed group");

  // Input stalls only behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // Zero level gives silence
  a_zero_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && level == '0 |-> left_out == '0 && right_out == '0)
    else $error("nonzero output at zero level");

endmodule

bind stereo_box_decimator_gain_top sbdg_assert #(
  .DECIMATION (DECIMATION)
) u_sbdg_assert (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (frame_in.valid),
  .in_ready  (frame_in.ready),
  .out_valid (frame_out.valid),
  .out_ready (frame_out.ready),
  .left_out  (frame_out.left_out),
  .right_out (frame_out.right_out),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .cfg_level (cfg.gain)
);

`default_nettype wire

@@ dv/sbdg_checker.sv @@
// Checker for the stereo box decimator with gain: watches the three channels,
// predicts every output frame and compares it. Depends on sbdg_pkg and sbdg_if.sv.
`timescale 1ns / 1ps

module sbdg_checker #(
  parameter int unsigned DECIMATION = sbdg_pkg::DECIMATION_DEFAULT
) (
  input wire logic          clk,
  input wire logic          rst,
  sbdg_frame_in_if          frame_in,
  sbdg_frame_out_if         frame_out,
  sbdg_cfg_if               cfg,
  output int unsigned       n_errors,
  output int unsigned       n_pending,
  output int unsigned       n_results
);

  typedef struct packed {
    logic signed [sbdg_pkg::SAMPLE_W-1:0] left;
    logic signed [sbdg_pkg::SAMPLE_W-1:0] right;
  } stereo_t;

  localparam int UNITY = 50;

  stereo_t                          expected_frames[$];
  stereo_t                          want;
  logic [sbdg_pkg::LEVEL_W-1:0]     gain_level;
  int unsigned                      frames_in_group;
  logic signed [18:0]               left_acc;
  logic signed [18:0]               right_acc;
  int unsigned                      error_cnt = 0;
  int unsigned                      result_cnt = 0;

  // Average a group sum, apply the level in fiftieths, clamp to 16 bits
  function automatic logic signed [sbdg_pkg::SAMPLE_W-1:0] scale_group(
    input logic signed [18:0] sum,
    input logic [sbdg_pkg::LEVEL_W-1:0] level
  );
    int avg;
    int gained;
    avg = int'(sum) / int'(DECIMATION);
    gained = (avg * int'(level)) / UNITY;
    if (gained > int'(sbdg_pkg::SAT_MAX)) begin
      gained = int'(sbdg_pkg::SAT_MAX);
    end else if (gained < int'(sbdg_pkg::SAT_MIN)) begin
      gained = int'(sbdg_pkg::SAT_MIN);
    end
    return gained[sbdg_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  // Track level writes, predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    if (rst) begin
      gain_level = sbdg_pkg::LEVEL_RESET;
      frames_in_group = 0;
      left_acc = '0;
      right_acc = '0;
      expected_frames.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        gain_level = cfg.gain;
      end

      // Check the output before queueing anything new from this edge
      if (frame_out.valid && frame_out.ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("output frame %0d (%0d, %0d) with nothing expected",
                                    result_cnt, frame_out.left_out, frame_out.right_out));
        end else begin
          want = expected_frames.pop_front();
          if (frame_out.left_out !== want.left) begin
            report_mismatch($sformatf("output frame %0d left_out got %0d expected %0d",
                                      result_cnt, frame_out.left_out, want.left));
          end
          if (frame_out.right_out !== want.right) begin
            report_mismatch($sformatf("output frame %0d right_out got %0d expected %0d",
                                      result_cnt, frame_out.right_out, want.right));
          end
        end
        result_cnt++;
      end

      // Accumulate the group; close it on its last frame
      if (frame_in.valid && frame_in.ready) begin
        left_acc = left_acc + frame_in.left_in;
        right_acc = right_acc + frame_in.right_in;
        if (frames_in_group + 1 < DECIMATION) begin
          frames_in_group++;
        end else begin
          want.left = scale_group(left_acc, gain_level);
          want.right = scale_group(right_acc, gain_level);
          expected_frames.push_back(want);
          frames_in_group = 0;
          left_acc = '0;
          right_acc = '0;
        end
      end
    end
    n_errors <= error_cnt;
    n_pending <= expected_frames.size();
    n_results <= result_cnt;
  end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the stereo box decimator with gain: clock, reset, frame and
// level stimulus, output back-pressure, watchdog and verdict. Uses sbdg_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DECIM        = sbdg_pkg::DECIMATION_DEFAULT;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD    = 48;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned PHASE_FRAMES = 85;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned HOLD_PHASE   = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbdg_frame_in_if  frame_in_ch();
  sbdg_frame_out_if frame_out_ch();
  sbdg_cfg_if       cfg_ch();

  int unsigned n_errors;
  int unsigned n_pending;
  int unsigned n_results;

  int unsigned frames_sent;
  int unsigned level_writes;
  int unsigned quiet_cycles = 0;
  int unsigned hold_reqs;
  logic        src_idle_on;
  logic        snk_idle_on;

  stereo_box_decimator_gain_top #(.DECIMATION(DECIM)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .frame_in  (frame_in_ch),
    .frame_out (frame_out_ch),
    .cfg       (cfg_ch)
  );

  sbdg_checker #(.DECIMATION(DECIM)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .frame_in  (frame_in_ch),
    .frame_out (frame_out_ch),
    .cfg       (cfg_ch),
    .n_errors  (n_errors),
    .n_pending (n_pending),
    .n_results (n_results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly full-range samples, with the extremes and values near zero mixed in
  function automatic logic signed [sbdg_pkg::SAMPLE_W-1:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 9))
      0: return sbdg_pkg::SAT_MAX;
      1: return sbdg_pkg::SAT_MIN;
      2: return 16'(int'($urandom_range(0, 16)) - 8);
      default: return raw[sbdg_pkg::SAMPLE_W-1:0];
    endcase
  endfunction

  // Offer one frame, optionally after a short gap, and hold it until the transfer
  task automatic send_frame(input logic signed [sbdg_pkg::SAMPLE_W-1:0] left,
                            input logic signed [sbdg_pkg::SAMPLE_W-1:0] right);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      frame_in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    frame_in_ch.valid <= 1'b1;
    frame_in_ch.left_in <= left;
    frame_in_ch.right_in <= right;
    do @(posedge clk); while (!frame_in_ch.ready);
    frames_sent++;
  endtask

  // Stop offering and wait until every expected frame is out, then let the
  // accumulator settle
  task automatic drain_pipeline();
    frame_in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic [sbdg_pkg::LEVEL_W-1:0] level);
    drain_pipeline();
    cfg_ch.valid <= 1'b1;
    cfg_ch.gain <= level;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    level_writes++;
  endtask

  // Output side: random short stalls, plus one long hold on request
  initial begin : sink_side
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left = 0;
    holds_done = 0;
    frame_out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        frame_out_ch.ready <= 1'b0;
      end else if (hold_reqs != holds_done) begin
        holds_done++;
        stall_left = LONG_HOLD - 1;
        frame_out_ch.ready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 2);
        frame_out_ch.ready <= 1'b0;
      end else begin
        frame_out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (frame_in_ch.valid && frame_in_ch.ready) ||
        (frame_out_ch.valid && frame_out_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d frames still expected",
               quiet_cycles, n_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [sbdg_pkg::LEVEL_W-1:0] phase_level;
    frame_in_ch.valid = 1'b0;
    frame_in_ch.left_in = '0;
    frame_in_ch.right_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.gain = sbdg_pkg::LEVEL_RESET;
    frames_sent = 0;
    level_writes = 0;
    hold_reqs = 0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed groups at the reset level: full-scale, sign swap, truncation
    repeat (DECIM) send_frame(sbdg_pkg::SAT_MAX, sbdg_pkg::SAT_MIN);
    repeat (DECIM) send_frame(sbdg_pkg::SAT_MIN, sbdg_pkg::SAT_MAX);
    send_frame(-16'sd1, 16'sd1);
    send_frame(-16'sd1, 16'sd1);
    send_frame(16'sd0, 16'sd0);
    send_frame(-16'sd5, 16'sd7);
    send_frame(16'sd0, 16'sd0);
    send_frame(16'sd0, 16'sd0);

    // Top level saturates full scale; moderate values scale
    write_level(7'd127);
    repeat (DECIM) send_frame(sbdg_pkg::SAT_MAX, sbdg_pkg::SAT_MIN);
    repeat (DECIM) send_frame(16'sd1000, -16'sd1000);

    // Zero level silences the output
    write_level(7'd0);
    repeat (DECIM) send_frame(sbdg_pkg::SAT_MAX, sbdg_pkg::SAT_MIN);

    // Double gain pushes into saturation
    write_level(7'd100);
    repeat (DECIM) send_frame(16'sd20000, -16'sd20000);

    // Random phases, each at its own level
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_level = 7'd1;
        1: phase_level = 7'd100;
        3: phase_level = 7'd127;
        5: phase_level = 7'd0;
        7: phase_level = sbdg_pkg::LEVEL_RESET;
        default: phase_level = sbdg_pkg::LEVEL_W'($urandom_range(0, 127));
      endcase
      write_level(phase_level);
      if (p == HOLD_PHASE) begin
        // Keep offering while the output holds off, so the pipeline backs up
        src_idle_on <= 1'b0;
        hold_reqs <= hold_reqs + 1;
      end else if (p == NUM_PHASES - 1) begin
        src_idle_on <= 1'b0;
        snk_idle_on <= 1'b0;
      end else begin
        src_idle_on <= 1'b1;
      end
      @(posedge clk);
      repeat (PHASE_FRAMES) send_frame(pick_sample(), pick_sample());
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d frames in, %0d output frames checked, %0d level writes",
             frames_sent, n_results, level_writes);
    $display("Covered full-scale and zero inputs, levels 0 to 127, saturation and a %0d-cycle stall",
             LONG_HOLD);
    if (n_errors == 0 && n_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
